>>> sv/fdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared types and constants of the floppy controller register block.
// ----------------------------------------------------------------------------
package fdc_pkg;

  localparam int unsigned MaxSectorBytes = 1024;

  typedef enum logic [1:0] {
    ACT_PORT_WR = 2'd0,
    ACT_PORT_RD = 2'd1,
    ACT_FILL    = 2'd2,
    ACT_DRAIN   = 2'd3
  } action_e;

  localparam logic [2:0] PORT_CMD   = 3'd0;
  localparam logic [2:0] PORT_TRACK = 3'd1;
  localparam logic [2:0] PORT_SECT  = 3'd2;
  localparam logic [2:0] PORT_DATA  = 3'd3;
  localparam logic [2:0] PORT_CTRL  = 3'd4;

  localparam logic [2:0] CFG_BPS   = 3'd0;
  localparam logic [2:0] CFG_SPT   = 3'd1;
  localparam logic [2:0] CFG_HEADS = 3'd2;
  localparam logic [2:0] CFG_IMAGE = 3'd3;
  localparam logic [2:0] CFG_MEDIA = 3'd4;
  localparam logic [2:0] CFG_WP    = 3'd5;

  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_FETCH = 2'd1;
  localparam logic [1:0] REQ_STORE = 2'd2;

  localparam logic [7:0] S_BUSY = 8'h01;
  localparam logic [7:0] S_DRQ  = 8'h02;
  localparam logic [7:0] S_TRK0 = 8'h04;
  localparam logic [7:0] S_RNF  = 8'h10;
  localparam logic [7:0] S_HLD  = 8'h20;
  localparam logic [7:0] S_WP   = 8'h40;
  localparam logic [7:0] S_NRDY = 8'h80;
  localparam logic [7:0] CTRL_BASE = 8'h08;
  localparam logic [3:0] IRQ_MASK  = 4'hF;

  // multiply-accumulate request to the shared unit
  typedef struct packed {
    logic        start;
    logic [24:0] a;
    logic [10:0] b;
    logic [24:0] c;
  } mac_req_t;

endpackage
`default_nettype wire

>>> sv/fdc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdc_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module fdc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

>>> sv/fdc_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdc_mac
// Shared multiply-accumulate unit: res = a * b + c, registered.
// ----------------------------------------------------------------------------
module fdc_mac
  import fdc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mac_req_t req_i,
  output logic          done_o,
  output logic [36:0]   res_o
);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= req_i.start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      res_o <= 37'(req_i.a * req_i.b) + 37'(req_i.c);
    end
  end
endmodule
`default_nettype wire

>>> sv/floppy_controller_registers.sv
`default_nettype none
// ----------------------------------------------------------------------------
// floppy_controller_registers
// 179x-style register block with sector buffer and media request stream.
// ----------------------------------------------------------------------------
// One beat is taken at a time. A port write, port read or media action passes
// through accept, buffer RAM read and result register. The fill beat that
// completes a sector also reads byte 0 back from the buffer into the data
// register. A READ or WRITE command runs the track/side/sector mapping through
// one shared multiply-accumulate unit, three passes plus a bounds check.
// in_stall_o is high while a beat is in work or its result waits to be taken.
module floppy_controller_registers
  import fdc_pkg::*;
#(
  parameter int unsigned MaxBytes = MaxSectorBytes
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [24:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [2:0]  port_i,
  input  wire logic [7:0]  byte_in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       read_value_o,
  output logic [1:0]       media_request_o,
  output logic [24:0]      media_offset_o,
  output logic [7:0]       media_byte_o,
  output logic             interrupt_line_o,
  output logic             data_request_o
);
  localparam int unsigned AW = $clog2(MaxBytes);
  localparam int unsigned LW = AW + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RAM, ST_EXEC, ST_MAC1, ST_MAC2, ST_MAC3, ST_FIRST, ST_LOC, ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    M_IDLE, M_FETCH, M_READ, M_WRITE, M_DRAIN
  } mode_e;

  state_e state_q;
  mode_e  mode_q;

  logic [10:0] bps_q;
  logic [5:0]  spt_q;
  logic [1:0]  heads_q;
  logic [24:0] image_q;
  logic        present_q, wp_q;

  logic [7:0]  track_q, sector_q, data_q, status_q, ctrl_q;
  logic        irq_q, drq_q;
  logic [LW-1:0] idx_q;
  logic [24:0] soff_q;

  logic [1:0]  act_q;
  logic [2:0]  port_q;
  logic [7:0]  bin_q;

  logic [7:0]  rv_q, mb_q;
  logic [1:0]  mr_q;
  logic [24:0] mo_q;

  logic [LW-1:0] len;
  always_comb begin
    if (bps_q == 11'd0) len = LW'(1);
    else if ({21'd0, bps_q} > 32'(MaxBytes)) len = LW'(MaxBytes);
    else len = LW'(bps_q);
  end

  // buffer RAM
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_rdata;
  logic          idx_ok;
  assign idx_ok = ({21'd0, idx_q} < 32'(MaxBytes));

  fdc_ram #(.Width(8), .Depth(MaxBytes)) u_buf (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(bin_q),
    .rdata_o(ram_rdata)
  );

  // shared MAC
  mac_req_t    mreq;
  logic        mdone;
  logic [36:0] mres;
  logic [36:0] acc_q;

  fdc_mac u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mreq),
    .done_o(mdone),
    .res_o (mres)
  );

  logic [24:0] acc25;
  assign acc25 = mres[24:0];

  always_comb begin
    mreq = '0;
    unique case (state_q)
      ST_EXEC: begin
        mreq.start = (act_q == ACT_PORT_WR) && (port_q == PORT_CMD) &&
                     (bin_q[7:6] == 2'b10);
        mreq.a = {17'd0, track_q};
        mreq.b = {9'd0, heads_q};
        mreq.c = {24'd0, ctrl_q[0]};
      end
      ST_MAC1: begin
        mreq.start = mdone;
        mreq.a = acc25;
        mreq.b = {5'd0, spt_q};
        mreq.c = {17'd0, sector_q - 8'd1};
      end
      ST_MAC2: begin
        mreq.start = mdone;
        mreq.a = acc25;
        mreq.b = 11'(len);
        mreq.c = '0;
      end
      default: mreq = '0;
    endcase
  end

  // ram address: in RAM state read byte idx (or 0 at fetch end)
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = idx_q[AW-1:0];
    if (state_q == ST_IDLE && in_valid_i && !in_stall_o) begin
      ram_addr = idx_q[AW-1:0];
    end
    if (state_q == ST_EXEC && idx_ok &&
        ((act_q == ACT_PORT_WR && port_q == PORT_DATA && mode_q == M_WRITE) ||
         (act_q == ACT_FILL && mode_q == M_FETCH))) begin
      ram_we = 1'b1;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bps_q <= 11'd512; spt_q <= 6'd9; heads_q <= 2'd2;
      image_q <= 25'd737280; present_q <= 1'b1; wp_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BPS:   bps_q <= cfg_data_i[10:0];
        CFG_SPT:   spt_q <= cfg_data_i[5:0];
        CFG_HEADS: heads_q <= cfg_data_i[1:0];
        CFG_IMAGE: image_q <= cfg_data_i;
        CFG_MEDIA: present_q <= cfg_data_i[0];
        CFG_WP:    wp_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic        bad_sec, fits;
  logic [7:0]  tnext;
  assign bad_sec = (sector_q == 8'd0) || (sector_q > {2'd0, spt_q});
  assign fits = (acc_q + 37'(len)) <= {12'd0, image_q};
  assign tnext = (bin_q[7:4] == 4'd0) ? 8'd0 :
                 (bin_q[7:4] == 4'd1) ? data_q : track_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; mode_q <= M_IDLE;
      track_q <= '0; sector_q <= 8'd1; data_q <= '0; status_q <= '0;
      ctrl_q <= '0; irq_q <= 1'b0; drq_q <= 1'b0; idx_q <= '0; soff_q <= '0;
      out_valid_o <= 1'b0;
      act_q <= '0; port_q <= '0; bin_q <= '0;
      rv_q <= '0; mb_q <= '0; mr_q <= REQ_NONE; mo_q <= '0; acc_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            act_q <= action_i; port_q <= port_i; bin_q <= byte_in_i;
            rv_q <= '0; mb_q <= '0; mr_q <= REQ_NONE; mo_q <= '0;
            state_q <= ST_RAM;
          end
        end
        ST_RAM: state_q <= ST_EXEC;
        ST_EXEC: begin
          state_q <= ST_OUT;
          unique case (act_q)
            ACT_PORT_WR: begin
              unique case (port_q)
                PORT_CMD: begin
                  if (bin_q[7] == 1'b0) begin
                    track_q <= tnext;
                    status_q <= S_HLD | ((tnext == 8'd0) ? S_TRK0 : 8'd0);
                    irq_q <= 1'b1; drq_q <= 1'b0; mode_q <= M_IDLE;
                  end else if (bin_q[7:6] == 2'b10) begin
                    if (!present_q || bad_sec) begin
                      status_q <= S_RNF; irq_q <= 1'b1; drq_q <= 1'b0;
                      mode_q <= M_IDLE;
                    end else begin
                      state_q <= ST_MAC1;
                    end
                  end else if (bin_q[7:4] == 4'hD) begin
                    status_q <= '0; irq_q <= (bin_q[3:0] & IRQ_MASK) != 4'd0;
                    drq_q <= 1'b0; mode_q <= M_IDLE;
                  end else begin
                    status_q <= S_RNF; irq_q <= 1'b1; drq_q <= 1'b0;
                    mode_q <= M_IDLE;
                  end
                end
                PORT_TRACK: track_q <= bin_q;
                PORT_SECT:  sector_q <= bin_q;
                PORT_CTRL:  ctrl_q <= bin_q;
                PORT_DATA: begin
                  if (mode_q == M_WRITE) begin
                    if (idx_q + LW'(1) >= len) begin
                      mode_q <= M_DRAIN; idx_q <= '0; drq_q <= 1'b0;
                      status_q <= S_BUSY; mr_q <= REQ_STORE; mo_q <= soff_q;
                    end else begin
                      idx_q <= idx_q + LW'(1);
                    end
                  end else begin
                    data_q <= bin_q;
                  end
                end
                default: ;
              endcase
            end
            ACT_PORT_RD: begin
              unique case (port_q)
                PORT_CMD:   rv_q <= status_q | (present_q ? 8'd0 : S_NRDY);
                PORT_TRACK: rv_q <= track_q;
                PORT_SECT:  rv_q <= sector_q;
                PORT_CTRL:  rv_q <= CTRL_BASE | {5'd0, irq_q, drq_q, 1'b0};
                PORT_DATA: begin
                  if (mode_q == M_READ) begin
                    data_q <= idx_ok ? ram_rdata : 8'd0;
                    rv_q <= idx_ok ? ram_rdata : 8'd0;
                    if (idx_q + LW'(1) >= len) begin
                      status_q <= '0; irq_q <= 1'b1; drq_q <= 1'b0;
                      mode_q <= M_IDLE;
                    end
                    idx_q <= idx_q + LW'(1);
                  end else begin
                    rv_q <= data_q;
                  end
                end
                default: rv_q <= '0;
              endcase
            end
            ACT_FILL: begin
              if (mode_q == M_FETCH) begin
                if (idx_q + LW'(1) >= len) begin
                  // byte 0 is read back through ST_FIRST and ST_LOC
                  mode_q <= M_READ; idx_q <= '0;
                  status_q <= S_BUSY | S_DRQ; drq_q <= 1'b1;
                  state_q <= ST_FIRST;
                end else begin
                  idx_q <= idx_q + LW'(1);
                end
              end
            end
            default: begin
              if (mode_q == M_DRAIN) begin
                mb_q <= idx_ok ? ram_rdata : 8'd0;
                if (idx_q + LW'(1) >= len) begin
                  status_q <= '0; irq_q <= 1'b1; drq_q <= 1'b0;
                  mode_q <= M_IDLE;
                end
                idx_q <= idx_q + LW'(1);
              end
            end
          endcase
        end
        ST_MAC1: if (mdone) state_q <= ST_MAC2;
        ST_MAC2: if (mdone) state_q <= ST_MAC3;
        ST_MAC3: if (mdone) begin
          acc_q <= mres;
          state_q <= ST_LOC;
        end
        ST_FIRST: state_q <= ST_LOC;
        ST_LOC: begin
          state_q <= ST_OUT;
          if (act_q == ACT_FILL) begin
            // after fetch completes, RAM holds byte 0 at address 0
            data_q <= ram_rdata;
          end else if (!fits) begin
            status_q <= S_RNF; irq_q <= 1'b1; drq_q <= 1'b0; mode_q <= M_IDLE;
          end else if (!bin_q[5]) begin
            mode_q <= M_FETCH; idx_q <= '0; soff_q <= acc_q[24:0];
            status_q <= S_BUSY; irq_q <= 1'b0; drq_q <= 1'b0;
            mr_q <= REQ_FETCH; mo_q <= acc_q[24:0];
          end else if (wp_q) begin
            status_q <= S_WP; irq_q <= 1'b1; drq_q <= 1'b0; mode_q <= M_IDLE;
          end else begin
            mode_q <= M_WRITE; idx_q <= '0; soff_q <= acc_q[24:0];
            status_q <= S_BUSY | S_DRQ; irq_q <= 1'b0; drq_q <= 1'b1;
          end
        end
        ST_OUT: begin
          if (out_valid_o && !out_stall_i) begin
            out_valid_o <= 1'b0;
            state_q <= ST_IDLE;
          end else begin
            out_valid_o <= 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign read_value_o     = rv_q;
  assign media_request_o  = mr_q;
  assign media_offset_o   = mo_q;
  assign media_byte_o     = mb_q;
  assign interrupt_line_o = irq_q;
  assign data_request_o   = drq_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o) else $error("accept while busy");
  a_req_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mr_q == REQ_NONE) |-> (mo_q == '0)) else $error("stray offset");
  a_drq_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && drq_q) |-> (mode_q == M_READ || mode_q == M_WRITE))
    else $error("drq outside cpu transfer");
endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the floppy register block. Bus and media beats come
// from a queue through a driver with random gaps. A predictor computes the
// result of each accepted beat, and a monitor with random stalls checks the
// block's results in order against the predicted ones.
// ----------------------------------------------------------------------------
module tb;
  import fdc_pkg::*;

  typedef struct packed {
    action_e    act;
    logic [2:0] port;
    logic [7:0] b;
  } beat_t;

  typedef struct packed {
    logic [7:0]  rv;
    logic [1:0]  req;
    logic [24:0] off;
    logic [7:0]  mb;
    logic        irq;
    logic        drq;
  } res_t;

  typedef enum logic [2:0] {XF_IDLE, XF_FETCH, XF_READ, XF_WRITE, XF_DRAIN} xfer_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [24:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  action_e     action = ACT_PORT_WR;
  logic [2:0]  port = '0;
  logic [7:0]  byte_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  read_value;
  logic [1:0]  media_request;
  logic [24:0] media_offset;
  logic [7:0]  media_byte;
  logic        interrupt_line;
  logic        data_request;

  floppy_controller_registers dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .action_i        (action),
    .port_i          (port),
    .byte_in_i       (byte_in),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .read_value_o    (read_value),
    .media_request_o (media_request),
    .media_offset_o  (media_offset),
    .media_byte_o    (media_byte),
    .interrupt_line_o(interrupt_line),
    .data_request_o  (data_request)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // controller model state
  int unsigned c_bps = 512, c_spt = 9, c_heads = 2, c_image = 737280;
  bit          c_media = 1'b1, c_wp = 1'b0;
  logic [7:0]  trk = 8'd0, sec = 8'd1, dat = 8'd0, stat = 8'd0, latch = 8'd0;
  logic        irq_f = 1'b0, drq_f = 1'b0;
  xfer_e       mode = XF_IDLE;
  int unsigned idx = 0;
  logic [24:0] soff = '0;
  logic [7:0]  sbuf [MaxSectorBytes];

  beat_t pend_beats[$];
  res_t  exp_results[$];
  int    errors = 0;
  int    n_items = 0;
  bit    tx_steady = 1'b0, rx_steady = 1'b0, want_hold = 1'b0;

  function automatic int unsigned sec_len();
    int unsigned n;
    n = c_bps;
    if (n < 1) n = 1;
    if (n > MaxSectorBytes) n = MaxSectorBytes;
    return n;
  endfunction

  function automatic bit locate(output longint unsigned o);
    longint unsigned lba, len;
    len = sec_len();
    o = 0;
    if (sec < 1 || sec > c_spt) return 1'b0;
    lba = (longint'(trk) * c_heads + latch[0]) * c_spt + (sec - 1);
    o = lba * len;
    return (o + len <= c_image);
  endfunction

  function automatic void end_cmd(logic [7:0] st, logic irq);
    stat = st;
    irq_f = irq;
    drq_f = 1'b0;
    mode = XF_IDLE;
  endfunction

  function automatic void run_cmd(input logic [7:0] c, inout res_t r);
    longint unsigned o;
    case (c[7:4])
      4'h8, 4'h9: begin
        if (!c_media || !locate(o)) begin
          end_cmd(S_RNF, 1'b1);
        end else begin
          mode = XF_FETCH;
          idx = 0;
          soff = o[24:0];
          stat = S_BUSY;
          irq_f = 1'b0;
          drq_f = 1'b0;
          r.req = REQ_FETCH;
          r.off = o[24:0];
        end
      end
      4'hA, 4'hB: begin
        if (!c_media || !locate(o)) end_cmd(S_RNF, 1'b1);
        else if (c_wp) end_cmd(S_WP, 1'b1);
        else begin
          mode = XF_WRITE;
          idx = 0;
          soff = o[24:0];
          stat = S_BUSY | S_DRQ;
          irq_f = 1'b0;
          drq_f = 1'b1;
        end
      end
      4'hD: end_cmd(8'h00, (c[3:0] & IRQ_MASK) != 0);
      4'hC, 4'hE, 4'hF: end_cmd(S_RNF, 1'b1);
      default: begin
        if (c[7:4] == 4'h0) trk = 8'd0;
        else if (c[7:4] == 4'h1) trk = dat;
        end_cmd(S_HLD | (trk == 0 ? S_TRK0 : 8'h00), 1'b1);
      end
    endcase
  endfunction

  function automatic res_t fdc_apply(beat_t t);
    res_t r;
    int unsigned len;
    r = '0;
    len = sec_len();
    case (t.act)
      ACT_PORT_WR: begin
        case (t.port)
          PORT_CMD:   run_cmd(t.b, r);
          PORT_TRACK: trk = t.b;
          PORT_SECT:  sec = t.b;
          PORT_CTRL:  latch = t.b;
          PORT_DATA: begin
            if (mode == XF_WRITE) begin
              sbuf[idx] = t.b;
              idx++;
              if (idx >= len) begin
                mode = XF_DRAIN;
                idx = 0;
                drq_f = 1'b0;
                stat = S_BUSY;
                r.req = REQ_STORE;
                r.off = soff;
              end
            end else begin
              dat = t.b;
            end
          end
          default: ;
        endcase
      end
      ACT_PORT_RD: begin
        case (t.port)
          PORT_CMD:   r.rv = stat | (c_media ? 8'h00 : S_NRDY);
          PORT_TRACK: r.rv = trk;
          PORT_SECT:  r.rv = sec;
          PORT_CTRL:  r.rv = CTRL_BASE | {5'd0, irq_f, drq_f, 1'b0};
          PORT_DATA: begin
            if (mode == XF_READ) begin
              dat = sbuf[idx];
              idx++;
              if (idx >= len) end_cmd(8'h00, 1'b1);
            end
            r.rv = dat;
          end
          default: ;
        endcase
      end
      ACT_FILL: begin
        if (mode == XF_FETCH) begin
          sbuf[idx] = t.b;
          idx++;
          if (idx >= len) begin
            mode = XF_READ;
            idx = 0;
            dat = sbuf[0];
            stat = S_BUSY | S_DRQ;
            drq_f = 1'b1;
          end
        end
      end
      default: begin
        if (mode == XF_DRAIN) begin
          r.mb = sbuf[idx];
          idx++;
          if (idx >= len) end_cmd(8'h00, 1'b1);
        end
      end
    endcase
    r.irq = irq_f;
    r.drq = drq_f;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // driver
  int unsigned tx_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_valid && !in_stall)
        exp_results.push_back(fdc_apply('{act: action, port: port, b: byte_in}));
      if (in_valid && in_stall) begin
      end else if (tx_gap > 0) begin
        in_valid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (pend_beats.size() > 0) begin
        beat_t nb;
        nb = pend_beats.pop_front();
        in_valid <= 1'b1;
        action <= nb.act;
        port <= nb.port;
        byte_in <= nb.b;
        tx_gap <= tx_steady ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  // monitor and receiver stalls
  int unsigned rx_cnt = 0, hold_cnt = 0;
  bit          hold_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      rx_cnt <= 0;
      hold_cnt <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (exp_results.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          res_t e;
          e = exp_results.pop_front();
          if (read_value !== e.rv) report("read_value", read_value, e.rv);
          if (media_request !== e.req) report("media_request", media_request, e.req);
          if (media_offset !== e.off) report("media_offset", media_offset, e.off);
          if (media_byte !== e.mb) report("media_byte", media_byte, e.mb);
          if (interrupt_line !== e.irq) report("interrupt_line", interrupt_line, e.irq);
          if (data_request !== e.drq) report("data_request", data_request, e.drq);
        end
      end
      if (hold_cnt > 0) begin
        out_stall <= 1'b1;
        hold_cnt <= hold_cnt - 1;
      end else if (want_hold && !hold_done) begin
        out_stall <= 1'b1;
        hold_cnt <= 400;
        hold_done <= 1'b1;
      end else if (rx_cnt > 0) begin
        rx_cnt <= rx_cnt - 1;
      end else begin
        out_stall <= !rx_steady && ($urandom_range(0, 3) == 0);
        rx_cnt <= pick_gap();
      end
    end
  end

  task automatic put(action_e a, logic [2:0] p, logic [7:0] b);
    pend_beats.push_back('{act: a, port: p, b: b});
    n_items++;
  endtask

  task automatic noise(int unsigned n);
    repeat (n) put(action_e'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                   8'($urandom_range(0, 255)));
  endtask

  task automatic sector_xfer(bit wr, int unsigned max_trk);
    int unsigned len;
    len = sec_len();
    put(ACT_PORT_WR, PORT_TRACK, 8'($urandom_range(0, max_trk)));
    put(ACT_PORT_WR, PORT_SECT, 8'($urandom_range(1, c_spt < 1 ? 1 : c_spt)));
    put(ACT_PORT_WR, PORT_CTRL, 8'($urandom_range(0, 255)));
    put(ACT_PORT_WR, PORT_CMD, (wr ? 8'hA0 : 8'h80) | 8'($urandom_range(0, 31)));
    repeat (len) begin
      if (wr) put(ACT_PORT_WR, PORT_DATA, 8'($urandom_range(0, 255)));
      else put(ACT_FILL, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 15) == 0) put(ACT_PORT_RD, PORT_CTRL, 8'($urandom_range(0, 255)));
    end
    repeat (len) begin
      if (wr) put(ACT_DRAIN, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      else put(ACT_PORT_RD, PORT_DATA, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 15) == 0) put(ACT_PORT_RD, PORT_CMD, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic settle();
    while (!(pend_beats.size() == 0 && !in_valid && !in_stall && exp_results.size() == 0))
      @(negedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic cfg_set(logic [2:0] i, int unsigned v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= i;
    cfg_data <= v[24:0];
    case (i)
      CFG_BPS:   c_bps = v & 32'h7FF;
      CFG_SPT:   c_spt = v & 32'h3F;
      CFG_HEADS: c_heads = v & 32'h3;
      CFG_IMAGE: c_image = v & 32'h1FFFFFF;
      CFG_MEDIA: c_media = v[0];
      CFG_WP:    c_wp = v[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // abort any open transfer, drain, then reprogram all configuration registers
  task automatic new_phase(int unsigned bps, int unsigned spt, int unsigned heads,
                           int unsigned image, int unsigned media, int unsigned wp);
    put(ACT_PORT_WR, PORT_CMD, 8'hD0);
    settle();
    cfg_set(CFG_BPS, bps);
    cfg_set(CFG_SPT, spt);
    cfg_set(CFG_HEADS, heads);
    cfg_set(CFG_IMAGE, image);
    cfg_set(CFG_MEDIA, media);
    cfg_set(CFG_WP, wp);
    tx_steady = ($urandom_range(0, 3) == 0);
    rx_steady = ($urandom_range(0, 3) == 0);
  endtask

  initial begin
    int unsigned bps, k;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: defaults after reset, then port writes and commands
    for (k = 0; k < 8; k++) put(ACT_PORT_RD, 3'(k), 8'hFF);
    put(ACT_PORT_WR, 3'd5, 8'hFF);
    put(ACT_PORT_WR, 3'd7, 8'h00);
    put(ACT_PORT_WR, PORT_DATA, 8'hFF);
    put(ACT_PORT_WR, PORT_CMD, 8'h1F);
    put(ACT_PORT_RD, PORT_CMD, 8'h00);
    put(ACT_PORT_WR, PORT_CMD, 8'h00);
    put(ACT_PORT_WR, PORT_CMD, 8'h7F);
    put(ACT_PORT_WR, PORT_CMD, 8'hC0);
    put(ACT_PORT_WR, PORT_CMD, 8'hFF);
    put(ACT_PORT_WR, PORT_CMD, 8'hDF);
    put(ACT_PORT_WR, PORT_CMD, 8'hD0);
    put(ACT_FILL, PORT_CMD, 8'hAA);
    put(ACT_DRAIN, PORT_CMD, 8'h55);
    put(ACT_PORT_WR, PORT_SECT, 8'h00);
    put(ACT_PORT_WR, PORT_CMD, 8'h80);
    put(ACT_PORT_WR, PORT_SECT, 8'd10);
    put(ACT_PORT_WR, PORT_CMD, 8'hA0);

    // one-byte sectors, full flows, side bit with one head
    new_phase(0, 1, 1, 33554431, 1, 0);
    sector_xfer(1'b0, 255);
    sector_xfer(1'b1, 255);
    new_phase(1, 63, 2, 0, 1, 0);
    sector_xfer(1'b0, 3);
    new_phase(1, 9, 2, 737280, 0, 1);
    sector_xfer(1'b0, 3);
    sector_xfer(1'b1, 3);
    put(ACT_PORT_RD, PORT_CMD, 8'h00);
    new_phase(1, 9, 2, 737280, 1, 1);
    sector_xfer(1'b1, 3);
    // largest sector, partial transfer then abort
    new_phase(2047, 63, 3, 33554431, 1, 0);
    put(ACT_PORT_WR, PORT_TRACK, 8'hFF);
    put(ACT_PORT_WR, PORT_SECT, 8'd63);
    put(ACT_PORT_WR, PORT_CTRL, 8'h01);
    put(ACT_PORT_WR, PORT_CMD, 8'h80);
    put(ACT_PORT_WR, PORT_TRACK, 8'd100);
    put(ACT_PORT_WR, PORT_CMD, 8'h9F);
    noise(4);
    repeat (20) put(ACT_FILL, PORT_DATA, 8'($urandom_range(0, 255)));
    put(ACT_PORT_WR, PORT_CMD, 8'hB0);
    repeat (20) put(ACT_PORT_WR, PORT_DATA, 8'($urandom_range(0, 255)));
    // receiver holds off while the sender keeps going
    new_phase(128, 18, 2, 33554431, 1, 0);
    want_hold = 1'b1;
    tx_steady = 1'b1;
    sector_xfer(1'b1, 20);

    while (n_items < 1000) begin
      k = $urandom_range(0, 99);
      bps = k < 55 ? $urandom_range(1, 8) : k < 85 ? 128 : k < 95 ? $urandom_range(9, 40) : 0;
      new_phase(bps, $urandom_range(1, 63), $urandom_range(0, 7) == 0 ? 3 : $urandom_range(1, 2),
                $urandom_range(0, 7) == 0 ? $urandom_range(0, 8191) : 33554431,
                $urandom_range(0, 9) != 0, $urandom_range(0, 4) == 0);
      repeat ($urandom_range(2, 5)) begin
        if (n_items >= 1000) break;
        if ($urandom_range(0, 9) < 7) sector_xfer($urandom_range(0, 1), 
                                                  $urandom_range(0, 3) == 0 ? 255 : 7);
        else noise($urandom_range(1, 8));
      end
    end

    settle();
    repeat (30) @(posedge clk_i);
    if (errors == 0) $display("floppy_controller_registers test passed");
    else $display("floppy_controller_registers test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("floppy_controller_registers test failed");
    $finish;
  end

endmodule

>>> files.f
sv/fdc_pkg.sv
sv/fdc_ram.sv
sv/fdc_mac.sv
sv/floppy_controller_registers.sv
verif/tb.sv
